### hdl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

    // Input and result field widths
    localparam int MODE_W    = 1;
    localparam int BLOCK_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int GROUP_W   = 9;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Group size after reset
    localparam logic [GROUP_W-1:0] GROUP_SIZE_RESET = 9'd16;

    // Request kinds carried in the mode field
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_NOT_IN_USE  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GET,
        S_PUT1,
        S_PUT2
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;  // write one identity entry of each table
        logic load;   // capture request, issue table reads, form product
        logic get;    // finish a get and load the result register
        logic put1;   // check a put and write the first entry pair
        logic put2;   // write the second entry pair and load the result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last entry
        logic out_free;    // result register can take a new result
        logic in_mode;     // mode field of the offered transaction
    } t_ctrl_sts;

endpackage

### hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: controller plus datapath.
// A get loads the result register from S_GET; a put goes through S_PUT1, then loads it from S_PUT2.
// A new request is taken only in S_IDLE, so each get or put finishes before the next; a put writes two entries of each
// table through its single write port. A full result register stalls completion.
// Reset: synchronous, active low; a clearing pass then writes every entry of
// both tables to identity while s_axis_tready stays low (configuration still taken).
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [0] mode, [8:1] block_index, [15:9] zero
    input  logic [fbpa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] status, [9:2] granted_block, [18:10] used_count, [27:19] capacity, [31:28] zero
    output logic [fbpa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [fbpa_pkg::GROUP_W-1:0]    i_cfg_wr_data
);

    import fbpa_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // Sequencer
    fbpa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // Tables and arithmetic
    fbpa_dpath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

### hdl/fbpa_ram.sv
// Single write port, single registered read port table memory.
module fbpa_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fbpa_ctrl.sv
// Sequencing state machine for the fixed block pool allocator.
module fbpa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  fbpa_pkg::t_ctrl_sts   i_sts,
    output fbpa_pkg::t_ctrl_cmd   o_cmd
);

    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_sts.in_mode == MODE_PUT) ? S_PUT1 : S_GET;
                end
            end
            S_GET: begin
                if (i_sts.out_free) begin
                    o_cmd.get = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PUT1: begin
                o_cmd.put1 = 1'b1;
                n_state    = S_PUT2;
            end
            S_PUT2: begin
                if (i_sts.out_free) begin
                    o_cmd.put2 = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### hdl/fbpa_dpath.sv
// Tables, counters, capacity arithmetic and result register of the allocator.
module fbpa_dpath #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [fbpa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [fbpa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [fbpa_pkg::GROUP_W-1:0]    i_cfg_wr_data,
    input  fbpa_pkg::t_ctrl_cmd             i_cmd,
    output fbpa_pkg::t_ctrl_sts             o_sts
);

    import fbpa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);          // table index width
    localparam int CW = $clog2(MAX_BLOCKS + 1);      // count width, holds MAX_BLOCKS
    localparam int XW = (CW > GROUP_W) ? CW + 1 : GROUP_W + 1;
    localparam int PW = 2 * CW + 1;                  // product plus one group

    // Input fields
    logic               in_mode;
    logic [BLOCK_W-1:0] in_blk;
    assign in_mode = i_s_axis_tdata[0];
    assign in_blk  = i_s_axis_tdata[BLOCK_W:1];

    // Registers
    logic [GROUP_W-1:0]  r_group_size;
    logic [CW-1:0]       r_groups,   n_groups;
    logic [CW-1:0]       r_used,     n_used;
    logic [AW-1:0]       r_clr_addr;
    logic [BLOCK_W-1:0]  r_blk;
    logic [AW-1:0]       r_last;
    logic [2*CW-1:0]     r_prod;
    logic [CW-1:0]       r_geff;
    logic                r_bad,      n_bad;
    logic                r_valid;
    t_status             r_status,   n_status;
    logic [BLOCK_W-1:0]  r_granted,  n_granted;
    logic [COUNT_W-1:0]  r_used_out, n_used_out;
    logic [COUNT_W-1:0]  r_cap_out,  n_cap_out;

    // Table ports
    logic          s_we, s_re, p_we, p_re;
    logic [AW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
    logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;

    // Effective group size: zero acts as one, capped at MAX_BLOCKS
    logic [XW-1:0] gx;
    logic [CW-1:0] geff;
    always_comb begin
        gx = XW'(r_group_size);
        if (gx == '0) begin
            geff = CW'(1);
        end else if (gx > XW'(MAX_BLOCKS)) begin
            geff = CW'(MAX_BLOCKS);
        end else begin
            geff = CW'(gx);
        end
    end

    // Capacity arithmetic on the registered product
    logic [PW-1:0] prod_x, grown_x, new_prod_x, cap_x, new_cap_x, used_x;
    logic          full, grow, exhausted, put_bad;
    always_comb begin
        prod_x     = PW'(r_prod);
        grown_x    = prod_x + PW'(r_geff);
        used_x     = PW'(r_used);
        cap_x      = (prod_x > PW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : prod_x;
        full       = used_x >= cap_x;
        grow       = full && (grown_x <= PW'(MAX_BLOCKS));
        new_prod_x = grow ? grown_x : prod_x;
        new_cap_x  = (new_prod_x > PW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : new_prod_x;
        exhausted  = (used_x >= new_cap_x) || (r_used >= CW'(MAX_BLOCKS));
        put_bad    = (r_used == '0) || (XW'(r_blk) >= XW'(MAX_BLOCKS))
                     || (CW'(p_rdata) >= r_used);
    end

    // Table port selection
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_clr_addr;
        s_wdata = r_clr_addr;
        p_we    = 1'b0;
        p_waddr = r_clr_addr;
        p_wdata = r_clr_addr;
        s_re    = i_cmd.load;
        s_raddr = (in_mode == MODE_PUT) ? AW'(r_used - CW'(1)) : AW'(r_used);
        p_re    = i_cmd.load;
        p_raddr = AW'(in_blk);
        if (i_cmd.clear) begin
            s_we = 1'b1;
            p_we = 1'b1;
        end else if (i_cmd.put1) begin
            // freed block to the last used slot
            s_we    = !put_bad;
            s_waddr = r_last;
            s_wdata = AW'(r_blk);
            p_we    = !put_bad;
            p_waddr = AW'(r_blk);
            p_wdata = r_last;
        end else if (i_cmd.put2) begin
            // displaced block to the freed block's old slot
            s_we    = !r_bad;
            s_waddr = p_rdata;
            s_wdata = s_rdata;
            p_we    = !r_bad;
            p_waddr = s_rdata;
            p_wdata = p_rdata;
        end
    end

    // Next values of counters and result
    always_comb begin
        n_groups   = r_groups;
        n_used     = r_used;
        n_bad      = r_bad;
        n_status   = r_status;
        n_granted  = r_granted;
        n_used_out = r_used_out;
        n_cap_out  = r_cap_out;
        if (i_cmd.get) begin
            if (grow) begin
                n_groups = r_groups + CW'(1);
            end
            if (exhausted) begin
                n_status  = ST_EXHAUSTED;
                n_granted = '0;
            end else begin
                n_status  = ST_OK;
                n_granted = BLOCK_W'(s_rdata);
                n_used    = r_used + CW'(1);
            end
            n_used_out = COUNT_W'(n_used);
            n_cap_out  = COUNT_W'(new_cap_x);
        end
        if (i_cmd.put1) begin
            n_bad = put_bad;
            if (!put_bad) begin
                n_used = r_used - CW'(1);
            end
        end
        if (i_cmd.put2) begin
            n_status   = r_bad ? ST_NOT_IN_USE : ST_OK;
            n_granted  = '0;
            n_used_out = COUNT_W'(r_used);
            n_cap_out  = COUNT_W'(cap_x);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RESET;
            r_groups     <= CW'(1);
            r_used       <= '0;
            r_clr_addr   <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_group_size <= i_cfg_wr_data;
            end
            r_groups <= n_groups;
            r_used   <= n_used;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.get || i_cmd.put2) begin
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk  <= in_blk;
            r_last <= AW'(r_used - CW'(1));
            r_prod <= r_groups * geff;
            r_geff <= geff;
        end
        r_bad      <= n_bad;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_used_out <= n_used_out;
        r_cap_out  <= n_cap_out;
    end

    // Slot table: slot to block number
    fbpa_ram #(.DEPTH(MAX_BLOCKS), .AW(AW), .DW(AW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Position table: block number to slot
    fbpa_ram #(.DEPTH(MAX_BLOCKS), .AW(AW), .DW(AW)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // Status to controller and result port
    assign o_sts.clear_last = (r_clr_addr == AW'(MAX_BLOCKS - 1));
    assign o_sts.out_free   = !r_valid || i_m_axis_tready;
    assign o_sts.in_mode    = in_mode;

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {4'b0, r_cap_out, r_used_out, r_granted, r_status};

endmodule

### tb/sv/tb_fixed_block_pool_allocator.sv
// Testbench for the fixed block pool allocator: random get/put traffic checked against a pool model.
module tb_fixed_block_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int POOL_BLOCKS = 256;
    localparam int STALL_LIMIT = 2000;   // cycles without any transaction before giving up
    localparam int LONG_HOLD   = 200;    // receiver back-pressure stretch
    localparam int HOLD_AT     = 250;    // result count that starts the long hold

    typedef struct packed {
        logic             mode;
        logic [BLOCK_W-1:0] blk;
    } t_pool_req;

    typedef struct packed {
        t_status            status;
        logic [BLOCK_W-1:0] granted;
        logic [COUNT_W-1:0] used;
        logic [COUNT_W-1:0] capacity;
    } t_pool_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [GROUP_W-1:0]    i_cfg_wr_data = '0;

    // Pool model state
    logic [BLOCK_W-1:0] slot_of [POOL_BLOCKS];
    logic [BLOCK_W-1:0] pos_of [POOL_BLOCKS];
    int                 used_blocks = 0;
    int                 active_groups = 1;
    logic [GROUP_W-1:0] group_cfg = GROUP_SIZE_RESET;

    t_pool_req    req_queue[$];
    t_pool_result due_results[$];

    bit idle_enable = 1'b1;
    int fail_count = 0;
    int results_seen = 0;

    fixed_block_pool_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    // Group size as the pool applies it: 0 means 1, anything above the pool means the pool
    function automatic int eff_group_size();
        int g;
        g = int'(group_cfg);
        if (g == 0) g = 1;
        if (g > POOL_BLOCKS) g = POOL_BLOCKS;
        return g;
    endfunction

    function automatic int pool_capacity();
        int c;
        c = active_groups * eff_group_size();
        if (c > POOL_BLOCKS) c = POOL_BLOCKS;
        return c;
    endfunction

    // Apply one request to the model and queue the result it must produce
    task automatic predict_request(input logic mode, input logic [BLOCK_W-1:0] blk);
        t_pool_result res;
        int g;
        int cap;
        int tail_slot;
        int pos;
        logic [BLOCK_W-1:0] other;
        res.status  = ST_OK;
        res.granted = '0;
        g = eff_group_size();
        if (mode == MODE_GET) begin
            // full pool grows by a group when it still fits; growth sticks even if still full
            if (used_blocks >= pool_capacity() && (active_groups + 1) * g <= POOL_BLOCKS)
                active_groups++;
            if (used_blocks >= pool_capacity() || used_blocks >= POOL_BLOCKS) begin
                res.status = ST_EXHAUSTED;
            end else begin
                res.granted = slot_of[used_blocks];
                used_blocks++;
            end
        end else begin
            if (used_blocks == 0 || int'(pos_of[blk]) >= used_blocks) begin
                res.status = ST_NOT_IN_USE;
            end else begin
                // swap the freed block into the last used slot, both tables
                used_blocks--;
                tail_slot = used_blocks;
                other = slot_of[tail_slot];
                pos = int'(pos_of[blk]);
                slot_of[tail_slot] = blk;
                pos_of[blk] = tail_slot[BLOCK_W-1:0];
                slot_of[pos] = other;
                pos_of[other] = pos[BLOCK_W-1:0];
            end
        end
        cap = pool_capacity();
        res.used = used_blocks[COUNT_W-1:0];
        res.capacity = cap[COUNT_W-1:0];
        due_results.push_back(res);
    endtask

    // Request driver
    always @(posedge i_clk) begin : req_driver
        t_pool_req nxt;
        int send_gap;
        if (i_s_axis_tvalid && o_s_axis_tready)
            predict_request(i_s_axis_tdata[0], i_s_axis_tdata[BLOCK_W:1]);
        if (i_s_axis_tvalid && !o_s_axis_tready) begin
            // hold the offered transaction
        end else if (send_gap != 0) begin
            send_gap = send_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (req_queue.size() != 0) begin
            nxt = req_queue.pop_front();
            i_s_axis_tdata <= {{(IN_DATA_W-BLOCK_W-MODE_W){1'b0}}, nxt.blk, nxt.mode};
            i_s_axis_tvalid <= 1'b1;
            if (idle_enable && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 16);
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin : res_monitor
        t_pool_result want;
        t_status got_status;
        logic [BLOCK_W-1:0] got_granted;
        logic [COUNT_W-1:0] got_used;
        logic [COUNT_W-1:0] got_cap;
        int recv_gap;
        int hold_left;
        bit long_hold_done;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got_status  = t_status'(o_m_axis_tdata[1:0]);
            got_granted = o_m_axis_tdata[9:2];
            got_used    = o_m_axis_tdata[18:10];
            got_cap     = o_m_axis_tdata[27:19];
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d granted_block %0d used_count %0d",
                       got_status, got_granted, got_used);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (got_status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got_status);
                    fail_count++;
                end
                if (got_granted != want.granted) begin
                    $error("granted_block: expected %0d, actual %0d", want.granted, got_granted);
                    fail_count++;
                end
                if (got_used != want.used) begin
                    $error("used_count: expected %0d, actual %0d", want.used, got_used);
                    fail_count++;
                end
                if (got_cap != want.capacity) begin
                    $error("capacity: expected %0d, actual %0d", want.capacity, got_cap);
                    fail_count++;
                end
            end
        end
        // one long hold lets the block fill up and stall its input
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap = recv_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 16) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_fixed_block_pool_allocator failed");
                $finish;
            end
        end
    end

    // Queue one request, keeping only a short backlog so puts see a current pool
    task automatic issue_request(input logic mode, input logic [BLOCK_W-1:0] blk);
        t_pool_req r;
        while (req_queue.size() >= 2) @(negedge i_clk);
        r.mode = mode;
        r.blk = blk;
        req_queue.push_back(r);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || i_s_axis_tvalid || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_group_size(input logic [GROUP_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        group_cfg = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mixed traffic: most puts return a block that is in use, the rest are arbitrary
    task automatic run_phase(input logic [GROUP_W-1:0] grp, input int count,
                             input int get_pct, input bit idling);
        logic mode;
        logic [BLOCK_W-1:0] blk;
        wait_idle();
        write_group_size(grp);
        idle_enable = idling;
        for (int n = 0; n < count; n++) begin
            mode = ($urandom_range(0, 99) < get_pct) ? MODE_GET : MODE_PUT;
            if (mode == MODE_PUT && used_blocks > 0 && $urandom_range(0, 4) != 0)
                blk = slot_of[$urandom_range(0, used_blocks - 1)];
            else
                blk = BLOCK_W'($urandom_range(0, 255));
            issue_request(mode, blk);
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_BLOCKS; k++) begin
            slot_of[k] = k[BLOCK_W-1:0];
            pos_of[k] = k[BLOCK_W-1:0];
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: puts on an empty pool, extremes of block_index, double put, first growth
        issue_request(MODE_PUT, 8'd0);
        issue_request(MODE_GET, 8'd255);
        issue_request(MODE_GET, 8'd0);
        issue_request(MODE_PUT, 8'd255);
        issue_request(MODE_PUT, 8'd0);
        issue_request(MODE_PUT, 8'd0);
        issue_request(MODE_PUT, 8'd1);
        for (int n = 0; n < 18; n++)
            issue_request(MODE_GET, BLOCK_W'($urandom_range(0, 255)));

        // group size 0 acts as 1 and shrinks the pool under live blocks
        run_phase(9'd0, 40, 70, 1'b1);
        // oversized group size, capacity capped at the pool
        run_phase(9'd511, 40, 30, 1'b1);
        run_phase(9'd100, 50, 50, 1'b0);
        run_phase(9'd3, 40, 60, 1'b1);
        // whole-pool groups: fill to exhaustion where growth no longer fits
        run_phase(9'd256, 220, 98, 1'b1);
        run_phase(9'd1, 40, 30, 1'b1);
        run_phase(GROUP_SIZE_RESET, 50, 50, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_fixed_block_pool_allocator passed");
        else
            $display("tb_fixed_block_pool_allocator failed");
        $finish;
    end

endmodule
